// ----- src/cch_pkg.sv -----
`default_nettype none

package cch_pkg;

	localparam int unsigned PctW = 7;
	localparam int unsigned MsW = 32;
	localparam int unsigned MvW = 16;
	localparam int unsigned RegIdxW = 2;
	localparam int unsigned RearmMargin = 2;

	localparam logic [PctW-1:0] CutoffPctRst = PctW'(98);
	localparam logic [PctW-1:0] ResumePctRst = PctW'(95);
	localparam logic [MsW-1:0] FullHoldRst = MsW'(30000);
	localparam logic [MsW-1:0] ResumeHoldRst = MsW'(15000);

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_DISABLE = 2'd1,
		CMD_ENABLE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_PAUSED = 2'd1,
		EV_RESUMED = 2'd2,
		EV_HW_NOTICE = 2'd3
	} event_t;

	typedef enum logic [RegIdxW-1:0] {
		REG_CUTOFF_PCT = 2'd0,
		REG_RESUME_PCT = 2'd1,
		REG_FULL_HOLD = 2'd2,
		REG_RESUME_HOLD = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PctW-1:0] cutoff_pct;
		logic [PctW-1:0] resume_pct;
		logic [MsW-1:0] full_hold;
		logic [MsW-1:0] resume_hold;
	} cfg_t;

	typedef struct packed {
		logic cutoff_applied;
		logic full_run;
		logic [MsW-1:0] full_start;
		logic resume_run;
		logic [MsW-1:0] resume_start;
		logic notice_given;
	} state_t;

	typedef struct packed {
		logic [MsW-1:0] now_ms;
		logic mv_valid;
		logic [PctW-1:0] pct;
		logic charging;
		logic control;
		logic accepted;
	} item_t;

	typedef struct packed {
		cmd_t cmd;
		event_t evt;
		logic cutoff_active;
	} result_t;

endpackage

`default_nettype wire

// ----- src/cch_core.sv -----
`default_nettype none

module cch_core (
	input  cch_pkg::cfg_t   cfg,
	input  cch_pkg::state_t state,
	input  cch_pkg::item_t  item,
	output cch_pkg::state_t state_nxt,
	output cch_pkg::result_t result
);

	logic [cch_pkg::MsW-1:0] full_start_eff;
	logic [cch_pkg::MsW-1:0] resume_start_eff;
	logic [cch_pkg::MsW-1:0] full_elapsed;
	logic [cch_pkg::MsW-1:0] resume_elapsed;
	logic [cch_pkg::PctW:0] pct_margin;
	logic full_cond;
	logic resume_cond;

	assign full_start_eff = state.full_run ? state.full_start : item.now_ms;
	assign resume_start_eff = state.resume_run ? state.resume_start : item.now_ms;
	assign full_elapsed = item.now_ms - full_start_eff;
	assign resume_elapsed = item.now_ms - resume_start_eff;
	assign pct_margin = {1'b0, item.pct} + (cch_pkg::PctW+1)'(cch_pkg::RearmMargin);

	assign full_cond = (item.pct >= cfg.cutoff_pct) && item.charging && !state.cutoff_applied;
	assign resume_cond = state.cutoff_applied && (item.pct <= cfg.resume_pct);

	always_comb begin
		state_nxt = state;
		result.cmd = cch_pkg::CMD_NONE;
		result.evt = cch_pkg::EV_NONE;
		if (!item.mv_valid) begin
			state_nxt.full_run = 1'b0;
			state_nxt.resume_run = 1'b0;
		end else if (full_cond) begin
			state_nxt.full_run = 1'b1;
			state_nxt.full_start = full_start_eff;
			state_nxt.resume_run = 1'b0;
			if (full_elapsed >= cfg.full_hold) begin
				if (item.control) begin
					result.cmd = cch_pkg::CMD_DISABLE;
					if (item.accepted) begin
						state_nxt.cutoff_applied = 1'b1;
						state_nxt.full_run = 1'b0;
						result.evt = cch_pkg::EV_PAUSED;
					end
				end else if (!state.notice_given) begin
					state_nxt.notice_given = 1'b1;
					result.evt = cch_pkg::EV_HW_NOTICE;
				end
			end
		end else if (resume_cond) begin
			state_nxt.resume_run = 1'b1;
			state_nxt.resume_start = resume_start_eff;
			state_nxt.full_run = 1'b0;
			if (resume_elapsed >= cfg.resume_hold) begin
				if (item.control) begin
					result.cmd = cch_pkg::CMD_ENABLE;
					if (item.accepted) begin
						state_nxt.cutoff_applied = 1'b0;
						state_nxt.resume_run = 1'b0;
						result.evt = cch_pkg::EV_RESUMED;
					end
				end else begin
					state_nxt.cutoff_applied = 1'b0;
					state_nxt.resume_run = 1'b0;
				end
			end
		end else begin
			state_nxt.full_run = 1'b0;
			if (!state.cutoff_applied) begin
				state_nxt.resume_run = 1'b0;
			end
			if (pct_margin <= {1'b0, cfg.resume_pct}) begin
				state_nxt.notice_given = 1'b0;
			end
		end
		result.cutoff_active = state_nxt.cutoff_applied;
	end

endmodule

`default_nettype wire

// ----- src/charge_cutoff_hysteresis.sv -----
`default_nettype none

// Battery charge hysteresis controller. Each input word is one battery check and yields exactly
// one result word after it is accepted: the check is captured in an input register,
// evaluated against the held state in one pass of compare and subtract logic, and the result
// lands in an output register while the state updates at the same edge. A new check is accepted
// every cycle as long as the output side is draining; a stalled result holds its check in the
// input register. Configuration writes complete in the cycle they are offered and should only be
// made while no check is in flight.
module charge_cutoff_hysteresis (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        in_valid,
	output       logic        in_stall,
	input  wire  logic [31:0] now_ms,
	input  wire  logic [15:0] battery_millivolts,
	input  wire  logic [6:0]  charge_percent,
	input  wire  logic        is_charging,
	input  wire  logic        control_available,
	input  wire  logic        write_accepted,
	output       logic        out_valid,
	input  wire  logic        out_stall,
	output       logic [1:0]  charge_command,
	output       logic [1:0]  event_code,
	output       logic        cutoff_active,
	input  wire  logic        cfg_valid,
	output       logic        cfg_ready,
	input  wire  logic [1:0]  cfg_index,
	input  wire  logic [31:0] cfg_data
);

	cch_pkg::cfg_t cfg_q;
	cch_pkg::state_t state_q;
	cch_pkg::state_t state_nxt;
	cch_pkg::item_t item_s1;
	cch_pkg::result_t result;
	cch_pkg::result_t result_s2;
	logic valid_s1;
	logic valid_s2;
	logic advance;
	logic in_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cutoff_pct <= cch_pkg::CutoffPctRst;
			cfg_q.resume_pct <= cch_pkg::ResumePctRst;
			cfg_q.full_hold <= cch_pkg::FullHoldRst;
			cfg_q.resume_hold <= cch_pkg::ResumeHoldRst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cch_pkg::reg_idx_t'(cfg_index))
				cch_pkg::REG_CUTOFF_PCT: cfg_q.cutoff_pct <= cfg_data[cch_pkg::PctW-1:0];
				cch_pkg::REG_RESUME_PCT: cfg_q.resume_pct <= cfg_data[cch_pkg::PctW-1:0];
				cch_pkg::REG_FULL_HOLD: cfg_q.full_hold <= cfg_data;
				cch_pkg::REG_RESUME_HOLD: cfg_q.resume_hold <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.now_ms <= now_ms;
			item_s1.mv_valid <= (battery_millivolts != 16'd0);
			item_s1.pct <= charge_percent;
			item_s1.charging <= is_charging;
			item_s1.control <= control_available;
			item_s1.accepted <= write_accepted;
		end
	end

	cch_core u_core (
		.cfg(cfg_q),
		.state(state_q),
		.item(item_s1),
		.state_nxt(state_nxt),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign charge_command = result_s2.cmd;
	assign event_code = result_s2.evt;
	assign cutoff_active = result_s2.cutoff_active;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a held word and a stalled result");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated word did not reach the output register");

	a_timers_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.full_run && state_q.resume_run))
		else $error("full and resume timers running together");

	a_paused_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.evt == cch_pkg::EV_PAUSED) |->
		(result_s2.cmd == cch_pkg::CMD_DISABLE && result_s2.cutoff_active))
		else $error("pause event without disable command or cutoff");

	a_resumed_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.evt == cch_pkg::EV_RESUMED) |->
		(result_s2.cmd == cch_pkg::CMD_ENABLE && !result_s2.cutoff_active))
		else $error("resume event without enable command or with cutoff held");

endmodule

`default_nettype wire

// ----- bench/charge_cutoff_checker.sv -----
`timescale 1ns / 100ps

module charge_cutoff_checker
	import cch_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic [15:0] battery_millivolts,
	input  wire logic [6:0]  charge_percent,
	input  wire logic        is_charging,
	input  wire logic        control_available,
	input  wire logic        write_accepted,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  charge_command,
	input  wire logic [1:0]  event_code,
	input  wire logic        cutoff_active,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               mismatches,
	output int               waiting
);

	cfg_t limits;
	state_t hyst;
	result_t owed_results[$];

	task automatic reset_model();
		limits.cutoff_pct = CutoffPctRst;
		limits.resume_pct = ResumePctRst;
		limits.full_hold = FullHoldRst;
		limits.resume_hold = ResumeHoldRst;
		hyst = '0;
		owed_results.delete();
		waiting = 0;
	endtask

	task automatic judge_check(
		input  logic [MsW-1:0]  now,
		input  logic [MvW-1:0]  mv,
		input  logic [PctW-1:0] pct,
		input  logic            chg,
		input  logic            ctl,
		input  logic            acc,
		output result_t         res
	);
		result_t r;
		logic [MsW-1:0] held;
		r.cmd = CMD_NONE;
		r.evt = EV_NONE;
		if (mv == '0) begin
			hyst.full_run = 1'b0;
			hyst.resume_run = 1'b0;
		end else if (pct >= limits.cutoff_pct && chg && !hyst.cutoff_applied) begin
			if (!hyst.full_run) begin
				hyst.full_run = 1'b1;
				hyst.full_start = now;
			end
			hyst.resume_run = 1'b0;
			held = now - hyst.full_start;
			if (held >= limits.full_hold) begin
				if (ctl) begin
					r.cmd = CMD_DISABLE;
					if (acc) begin
						hyst.cutoff_applied = 1'b1;
						hyst.full_run = 1'b0;
						r.evt = EV_PAUSED;
					end
				end else if (!hyst.notice_given) begin
					hyst.notice_given = 1'b1;
					r.evt = EV_HW_NOTICE;
				end
			end
		end else if (hyst.cutoff_applied && pct <= limits.resume_pct) begin
			if (!hyst.resume_run) begin
				hyst.resume_run = 1'b1;
				hyst.resume_start = now;
			end
			hyst.full_run = 1'b0;
			held = now - hyst.resume_start;
			if (held >= limits.resume_hold) begin
				if (ctl) begin
					r.cmd = CMD_ENABLE;
					if (acc) begin
						hyst.cutoff_applied = 1'b0;
						hyst.resume_run = 1'b0;
						r.evt = EV_RESUMED;
					end
				end else begin
					hyst.cutoff_applied = 1'b0;
					hyst.resume_run = 1'b0;
				end
			end
		end else begin
			hyst.full_run = 1'b0;
			if (!hyst.cutoff_applied)
				hyst.resume_run = 1'b0;
			if ({1'b0, pct} + 8'(RearmMargin) <= {1'b0, limits.resume_pct})
				hyst.notice_given = 1'b0;
		end
		r.cutoff_active = hyst.cutoff_applied;
		res = r;
	endtask

	initial begin
		mismatches = 0;
		reset_model();
	end

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_CUTOFF_PCT: limits.cutoff_pct = cfg_data[PctW-1:0];
					REG_RESUME_PCT: limits.resume_pct = cfg_data[PctW-1:0];
					REG_FULL_HOLD: limits.full_hold = cfg_data;
					REG_RESUME_HOLD: limits.resume_hold = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word cmd %0d event %0d cutoff %0b",
						$time, charge_command, event_code, cutoff_active);
				end else begin
					want = owed_results.pop_front();
					if (charge_command !== want.cmd || event_code !== want.evt ||
							cutoff_active !== want.cutoff_active) begin
						mismatches++;
						$display("%0t: expected cmd %0d event %0d cutoff %0b, actual cmd %0d event %0d cutoff %0b",
							$time, want.cmd, want.evt, want.cutoff_active,
							charge_command, event_code, cutoff_active);
					end
				end
			end
			if (in_valid && !in_stall) begin
				judge_check(now_ms, battery_millivolts, charge_percent, is_charging,
					control_available, write_accepted, fresh);
				owed_results.push_back(fresh);
			end
			waiting = owed_results.size();
		end
	end

endmodule

// ----- bench/tb_charge_cutoff_hysteresis.sv -----
`timescale 1ns / 100ps

module tb_charge_cutoff_hysteresis;

	localparam int Limit = 200000;
	localparam int PhaseItems = 145;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms = '0;
	logic [15:0] battery_millivolts = '0;
	logic [6:0]  charge_percent = '0;
	logic        is_charging = 1'b0;
	logic        control_available = 1'b0;
	logic        write_accepted = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  charge_command;
	logic [1:0]  event_code;
	logic        cutoff_active;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	int mismatches;
	int waiting;
	int sent_items = 0;
	int hold_left = 0;
	int seg_left = 0;
	int seg_kind = 0;
	bit calm = 1'b0;
	bit squeezed = 1'b0;
	logic [6:0]  cur_cut = cch_pkg::CutoffPctRst;
	logic [6:0]  cur_res = cch_pkg::ResumePctRst;
	logic [31:0] clock_ms = '0;

	charge_cutoff_hysteresis dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.battery_millivolts(battery_millivolts),
		.charge_percent(charge_percent),
		.is_charging(is_charging),
		.control_available(control_available),
		.write_accepted(write_accepted),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.charge_command(charge_command),
		.event_code(event_code),
		.cutoff_active(cutoff_active),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	charge_cutoff_checker check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.now_ms(now_ms),
		.battery_millivolts(battery_millivolts),
		.charge_percent(charge_percent),
		.is_charging(is_charging),
		.control_available(control_available),
		.write_accepted(write_accepted),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.charge_command(charge_command),
		.event_code(event_code),
		.cutoff_active(cutoff_active),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.waiting(waiting)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles <= Limit) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	// The one long hold-off fills the block so that it stalls its input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!squeezed && sent_items >= 400) begin
				squeezed = 1'b1;
				hold_left = 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(0, 99) < 8);
			end
		end
	end

	task automatic send_check(
		input logic [31:0] t,
		input logic [15:0] mv,
		input logic [6:0]  pct,
		input logic        chg,
		input logic        ctl,
		input logic        acc
	);
		in_valid <= 1'b1;
		now_ms <= t;
		battery_millivolts <= mv;
		charge_percent <= pct;
		is_charging <= chg;
		control_available <= ctl;
		write_accepted <= acc;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_items++;
		if (!calm && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic load_settings(
		input logic [6:0]  cut,
		input logic [6:0]  res,
		input logic [31:0] full_hold,
		input logic [31:0] resume_hold
	);
		logic [31:0] word [4];
		logic [31:0] noise;
		noise = $urandom;
		word[cch_pkg::REG_CUTOFF_PCT] = {noise[31:7], cut};
		noise = $urandom;
		word[cch_pkg::REG_RESUME_PCT] = {noise[31:7], res};
		word[cch_pkg::REG_FULL_HOLD] = full_hold;
		word[cch_pkg::REG_RESUME_HOLD] = resume_hold;
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= cch_pkg::reg_idx_t'(i);
			cfg_data <= word[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_cut = cut;
		cur_res = res;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
	endtask

	// Most runs of checks sit near the cutoff or the resume level so the timers can expire; the rest use random levels.
	task automatic random_check();
		int r;
		int p;
		logic [31:0] step;
		logic chg;
		logic [15:0] mv;
		if (seg_left == 0) begin
			seg_kind = $urandom_range(0, 9);
			seg_left = $urandom_range(2, 12);
		end
		seg_left--;
		r = $urandom_range(0, 99);
		if (r < 70)
			step = $urandom_range(0, 6000);
		else if (r < 90)
			step = $urandom_range(0, 40000);
		else if (r < 96)
			step = $urandom;
		else
			step = '1;
		clock_ms = clock_ms + step;
		if (seg_kind < 4) begin
			p = int'(cur_cut) + int'($urandom_range(0, 3));
			chg = ($urandom_range(0, 9) != 0);
		end else if (seg_kind < 8) begin
			p = int'(cur_res) - int'($urandom_range(0, 4));
			chg = 1'($urandom_range(0, 1));
		end else begin
			p = $urandom_range(0, 127);
			chg = 1'($urandom_range(0, 1));
		end
		if (p > 127)
			p = 127;
		if (p < 0)
			p = 0;
		mv = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
		send_check(clock_ms, mv, 7'(p), chg, $urandom_range(0, 99) < 85,
			$urandom_range(0, 99) < 85);
	endtask

	initial begin
		logic [6:0] cut;
		logic [6:0] res;
		logic [31:0] fh;
		logic [31:0] rh;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_check(32'd0, 16'd0, 7'd100, 1'b1, 1'b1, 1'b1);
		send_check(32'd1000, 16'd4200, 7'd98, 1'b1, 1'b1, 1'b1);
		send_check(32'd31000, 16'd4200, 7'd98, 1'b1, 1'b1, 1'b0);
		send_check(32'd31001, 16'd4200, 7'd98, 1'b1, 1'b1, 1'b1);
		send_check(32'd32000, 16'd4100, 7'd95, 1'b1, 1'b1, 1'b1);
		send_check(32'd47000, 16'd4100, 7'd95, 1'b1, 1'b1, 1'b0);
		send_check(32'd47001, 16'd4100, 7'd95, 1'b1, 1'b1, 1'b1);
		send_check(32'd50000, 16'd4200, 7'd100, 1'b1, 1'b0, 1'b1);
		send_check(32'd80000, 16'd4200, 7'd100, 1'b1, 1'b0, 1'b1);
		send_check(32'd90000, 16'd4200, 7'd100, 1'b1, 1'b0, 1'b1);
		send_check(32'd91000, 16'd4000, 7'd93, 1'b0, 1'b1, 1'b1);
		send_check(32'hFFFF0000, 16'hFFFF, 7'd100, 1'b1, 1'b0, 1'b1);
		send_check(32'h00006000, 16'hFFFF, 7'd100, 1'b1, 1'b0, 1'b1);
		send_check(32'h00007000, 16'd4300, 7'd127, 1'b1, 1'b1, 1'b1);
		send_check(32'h00008000, 16'd3300, 7'd0, 1'b0, 1'b1, 1'b1);
		send_check(32'h00009000, 16'd0, 7'd0, 1'b0, 1'b1, 1'b1);
		send_check(32'h0000A000, 16'd3300, 7'd0, 1'b0, 1'b1, 1'b1);
		send_check(32'h0000DA98, 16'd3300, 7'd0, 1'b0, 1'b0, 1'b1);
		send_check(32'h0000E000, 16'd4200, 7'd97, 1'b1, 1'b1, 1'b1);
		send_check(32'hFFFFFFFF, 16'd1, 7'd0, 1'b0, 1'b0, 1'b0);
		drain();

		clock_ms = 32'h00010000;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					cut = 7'd0;
					res = 7'd127;
					fh = '0;
					rh = '0;
				end
				1: begin
					cut = 7'd127;
					res = 7'd0;
					fh = '1;
					rh = '1;
				end
				2: begin
					cut = 7'd90;
					res = 7'd1;
					fh = 32'd2000;
					rh = 32'd1000;
				end
				3: begin
					cut = 7'd100;
					res = 7'd2;
					fh = 32'd5000;
					rh = 32'd5000;
				end
				4: begin
					cut = cch_pkg::CutoffPctRst;
					res = cch_pkg::ResumePctRst;
					fh = cch_pkg::FullHoldRst;
					rh = cch_pkg::ResumeHoldRst;
				end
				default: begin
					cut = 7'($urandom_range(40, 100));
					res = 7'($urandom_range(2, cut));
					fh = $urandom_range(0, 20000);
					rh = $urandom_range(0, 20000);
				end
			endcase
			load_settings(cut, res, fh, rh);
			calm = (ph == 3);
			repeat (PhaseItems)
				random_check();
			calm = 1'b0;
			drain();
		end

		repeat (10)
			@(posedge clk);
		if (mismatches == 0 && waiting == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/cch_pkg.sv
src/cch_core.sv
src/charge_cutoff_hysteresis.sv
bench/charge_cutoff_checker.sv
bench/tb_charge_cutoff_hysteresis.sv
